// File: hw/rtl/button_debounce_long_press_defines.svh
// assertion macros for the button debouncer
// no dependencies; taken in by the top level
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BDLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BDLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bdlp_pkg.sv
// shared types and constants for the button debouncer
// no dependencies; used by every module of the block
package bdlp_pkg;

  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned DEBOUNCE_W = 10;
  localparam int unsigned LONG_W     = 16;
  localparam int unsigned CHANGE_W   = 11;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned DEFAULT_BUTTON_COUNT = 2;

  localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 8'd10;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd30;
  localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd1000;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLL_PERIOD = 2'd0,
    CFG_DEBOUNCE    = 2'd1,
    CFG_LONG_PRESS  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]   poll_period_ms;
    logic [DEBOUNCE_W-1:0] debounce_time;
    logic [LONG_W-1:0]     long_press_ms;
  } cfg_t;

  // what one lane found on one tick
  typedef struct packed {
    logic short_hit;
    logic long_hit;
    logic pressed;
  } lane_res_t;

endpackage

// File: hw/rtl/bdlp_lane.sv
// per-button debounce and press timing lane
// depends on bdlp_pkg
module bdlp_lane
  import bdlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      tick,
  input  logic      raw_level,
  input  cfg_t      cfg,
  output lane_res_t res
);

  logic                pressed;
  logic [CHANGE_W-1:0] change_ms;
  logic [HOLD_W-1:0]   hold_ms;
  logic                long_done;

  logic                pressed_next;
  logic [CHANGE_W-1:0] change_ms_next;
  logic [HOLD_W-1:0]   hold_ms_next;
  logic                long_done_next;

  logic                down;
  logic [HOLD_W:0]     hold_sum;
  logic [HOLD_W-1:0]   hold_sat;
  logic [HOLD_W-1:0]   hold_adv;
  logic                long_hit;
  logic                long_adv;
  logic [CHANGE_W:0]   change_sum;
  logic [CHANGE_W-1:0] change_sat;
  logic                short_hit;

  assign down = ~raw_level;

  // hold timer, saturating
  assign hold_sum = {1'b0, hold_ms} + (HOLD_W+1)'(cfg.poll_period_ms);
  assign hold_sat = hold_sum[HOLD_W] ? {HOLD_W{1'b1}} : hold_sum[HOLD_W-1:0];
  assign hold_adv = pressed ? hold_sat : hold_ms;
  assign long_hit = pressed && !long_done && (hold_sat >= cfg.long_press_ms);
  assign long_adv = long_done | long_hit;

  // change timer, saturating
  assign change_sum = {1'b0, change_ms} + (CHANGE_W+1)'(cfg.poll_period_ms);
  assign change_sat = change_sum[CHANGE_W] ? {CHANGE_W{1'b1}} : change_sum[CHANGE_W-1:0];

  // next state of the lane
  always_comb begin
    pressed_next   = pressed;
    change_ms_next = '0;
    hold_ms_next   = hold_adv;
    long_done_next = long_adv;
    short_hit      = 1'b0;
    if (down != pressed) begin
      if (change_sat >= CHANGE_W'(cfg.debounce_time)) begin
        pressed_next = down;
        if (down) begin
          hold_ms_next   = '0;
          long_done_next = 1'b0;
        end else begin
          short_hit = !long_adv;
        end
      end else begin
        change_ms_next = change_sat;
      end
    end
  end

  // lane state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed   <= 1'b0;
      change_ms <= '0;
      hold_ms   <= '0;
      long_done <= 1'b0;
    end else if (tick) begin
      pressed   <= pressed_next;
      change_ms <= change_ms_next;
      hold_ms   <= hold_ms_next;
      long_done <= long_done_next;
    end
  end

  assign res.short_hit = short_hit;
  assign res.long_hit  = long_hit;
  assign res.pressed   = pressed_next;

endmodule

// File: hw/rtl/bdlp_merge.sv
// merges lane results into masks and buffers the result word
// depends on bdlp_pkg; two-entry output buffer (output register plus skid)
module bdlp_merge
  import bdlp_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = DEFAULT_BUTTON_COUNT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    tick,
  input  lane_res_t               res [BUTTON_COUNT],
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [BUTTON_COUNT-1:0] short_press_mask,
  output logic [BUTTON_COUNT-1:0] long_press_mask,
  output logic [BUTTON_COUNT-1:0] pressed_mask
);

  logic [BUTTON_COUNT-1:0] short_new;
  logic [BUTTON_COUNT-1:0] long_new;
  logic [BUTTON_COUNT-1:0] pressed_new;

  logic                    skid_valid;
  logic [BUTTON_COUNT-1:0] skid_short;
  logic [BUTTON_COUNT-1:0] skid_long;
  logic [BUTTON_COUNT-1:0] skid_pressed;
  logic                    out_take;

  // gather lane bits into masks
  always_comb begin
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      short_new[i]   = res[i].short_hit;
      long_new[i]    = res[i].long_hit;
      pressed_new[i] = res[i].pressed;
    end
  end

  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  // output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid && out_take) begin
      skid_valid <= 1'b0;
    end else if (tick) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // output buffer data
  always_ff @(posedge clk) begin
    if (skid_valid && out_take) begin
      short_press_mask <= skid_short;
      long_press_mask  <= skid_long;
      pressed_mask     <= skid_pressed;
    end else if (tick) begin
      if (!out_valid || out_take) begin
        short_press_mask <= short_new;
        long_press_mask  <= long_new;
        pressed_mask     <= pressed_new;
      end else begin
        skid_short   <= short_new;
        skid_long    <= long_new;
        skid_pressed <= pressed_new;
      end
    end
  end

endmodule

// File: hw/rtl/button_debounce_long_press.sv
// Debounced push buttons with short and long press detection.
// Input channel (in_valid / in_stall): one word per poll tick carrying
// raw_levels, one active-low bit per button. Output channel (out_valid /
// out_stall): exactly one word per input word with short_press_mask,
// long_press_mask and pressed_mask for that tick.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// index 0 poll period, 1 debounce time, 2 long press time, in ms; other
// indexes are dropped. cfg_ready is always high; write only while idle.
// One lane per button updates its timers in the cycle a word is taken,
// so a new word is accepted every cycle while in_stall is low. Results are
// registered in the output register, or in the skid entry while the receiver
// stalls: the two-entry buffer lets one more word in; in_stall rises only
// when both entries are full. Reset clears all button state (all released)
// and loads the default periods 10, 30 and 1000 ms; no clearing pass is needed.
// Depends on bdlp_pkg, bdlp_lane, bdlp_merge and the assertion macros.
`include "button_debounce_long_press_defines.svh"

module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = DEFAULT_BUTTON_COUNT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [BUTTON_COUNT-1:0] raw_levels,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [BUTTON_COUNT-1:0] short_press_mask,
  output logic [BUTTON_COUNT-1:0] long_press_mask,
  output logic [BUTTON_COUNT-1:0] pressed_mask,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  cfg_t      cfg;
  logic      tick;
  lane_res_t res [BUTTON_COUNT];

  assign cfg_ready = 1'b1;
  assign tick      = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_period_ms <= PERIOD_RESET;
      cfg.debounce_time  <= DEBOUNCE_RESET;
      cfg.long_press_ms  <= LONG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POLL_PERIOD: cfg.poll_period_ms <= cfg_data[PERIOD_W-1:0];
        CFG_DEBOUNCE:    cfg.debounce_time  <= cfg_data[DEBOUNCE_W-1:0];
        CFG_LONG_PRESS:  cfg.long_press_ms  <= cfg_data[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  // one lane per button
  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
    bdlp_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .tick      (tick),
      .raw_level (raw_levels[g]),
      .cfg       (cfg),
      .res       (res[g])
    );
  end

  // mask merge and output buffer
  bdlp_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .clk              (clk),
    .rst              (rst),
    .tick             (tick),
    .res              (res),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .short_press_mask (short_press_mask),
    .long_press_mask  (long_press_mask),
    .pressed_mask     (pressed_mask)
  );

  // checks
  `BDLP_ASSERT_NOW(a_stall_needs_out, clk, rst, in_stall, out_valid, "stall with empty output")
  `BDLP_ASSERT_NOW(a_short_long_excl, clk, rst, out_valid, (short_press_mask & long_press_mask) == '0, "short and long press on one button")
  `BDLP_ASSERT_NOW(a_short_released, clk, rst, out_valid, (short_press_mask & pressed_mask) == '0, "short press on a held button")
  `BDLP_ASSERT_NEXT(a_skid_fill, clk, rst, tick && out_valid && out_stall, in_stall, "skid entry not filled")

endmodule
